// ----- rtl/bsrs_pkg.sv -----
// ----------------------------------------------------------------------------
// bsrs_pkg
// Shared types and codes for the block-scoped rename stacks.
// ----------------------------------------------------------------------------
package bsrs_pkg;

    localparam int unsigned OP_BITS     = 2;
    localparam int unsigned VAR_BITS    = 6;
    localparam int unsigned BLOCK_BITS  = 16;
    localparam int unsigned NUMBER_BITS = 16;
    localparam int unsigned STATUS_BITS = 2;
    localparam int unsigned COUNT_BITS  = 9;

    localparam int unsigned S_TDATA_BITS = 40;
    localparam int unsigned M_TDATA_BITS = 32;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_BITS-1:0] OP_READ = 2'd1;
    localparam logic [OP_BITS-1:0] OP_POP  = 2'd2;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVF   = 2'd2;

    typedef struct packed {
        logic [BLOCK_BITS-1:0]  blk;
        logic [NUMBER_BITS-1:0] num;
    } t_entry;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] blk;
        logic [VAR_BITS-1:0]   var_idx;
    } t_log;

    // result, top_number in the lowest bits
    typedef struct packed {
        logic [COUNT_BITS-1:0]  popped_count;
        logic [STATUS_BITS-1:0] status;
        logic [NUMBER_BITS-1:0] top_number;
    } t_res;

endpackage

// ----- rtl/bsrs_ram.sv -----
// ----------------------------------------------------------------------------
// bsrs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bsrs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/block_scoped_rename_stacks_unit.sv -----
// ----------------------------------------------------------------------------
// block_scoped_rename_stacks_unit
// Per-variable rename stacks with a shared definition log.
// ----------------------------------------------------------------------------
// One item is handled at a time. A read goes from transfer to result
// through a stack height lookup, then a top entry lookup, as does a push;
// a read or push on an empty stack ends after the height lookup. A pop-block
// removes log entries one by one: each removal is a log read followed
// by a height read-modify-write. These steps come from the registered read
// data of the height, entry and log RAMs. After reset all min(NUM_VARS, 64)
// entries of the height RAM are swept to zero, during which no item is taken.
// A finished result sits in the output register, so the next item may be
// taken while it waits.
module block_scoped_rename_stacks_unit #(
    parameter int unsigned NUM_VARS    = 64,
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned LOG_DEPTH   = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [5:0] var_index, [21:6] block_id, [37:22] ssa_number, [39:38] zero
    input  logic [bsrs_pkg::S_TDATA_BITS-1:0] s_tdata,
    // [1:0] operation
    input  logic [bsrs_pkg::OP_BITS-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] top_number, [17:16] status, [26:18] popped_count, [31:27] zero
    output logic [bsrs_pkg::M_TDATA_BITS-1:0] m_tdata
);

    import bsrs_pkg::*;

    localparam int unsigned VARS  = (NUM_VARS < 64) ? NUM_VARS : 64;
    localparam int unsigned EDEP  = VARS * STACK_DEPTH;
    localparam int unsigned HA    = (VARS > 1) ? $clog2(VARS) : 1;
    localparam int unsigned EA    = (EDEP > 1) ? $clog2(EDEP) : 1;
    localparam int unsigned LA    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int unsigned HW    = $clog2(STACK_DEPTH + 1);
    localparam int unsigned LW    = $clog2(LOG_DEPTH + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_HGT  = 3'd2;
    localparam logic [2:0] S_ENT  = 3'd3;
    localparam logic [2:0] S_PCHK = 3'd4;
    localparam logic [2:0] S_PDEC = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // control registers
    logic [2:0]            r_state, n_state;
    logic [HA-1:0]         r_clr, n_clr;
    logic [LW-1:0]         r_log_h, n_log_h;
    logic                  r_m_valid, n_m_valid;
    // payload registers
    logic [OP_BITS-1:0]    r_op, n_op;
    logic [VAR_BITS-1:0]   r_var, n_var;
    logic [BLOCK_BITS-1:0] r_blk, n_blk;
    logic [NUMBER_BITS-1:0] r_num, n_num;
    logic [HW-1:0]         r_h, n_h;
    logic [VAR_BITS-1:0]   r_lvar, n_lvar;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    t_res                  r_res, n_res;
    t_res                  r_m_res, n_m_res;

    // memory ports
    logic          h_we;
    logic [HA-1:0] h_waddr, h_raddr;
    logic [HW-1:0] h_wdata, h_rdata;
    logic          e_we;
    logic [EA-1:0] e_waddr, e_raddr;
    t_entry        e_wdata, e_rdata;
    logic          l_we;
    logic [LA-1:0] l_waddr, l_raddr;
    t_log          l_wdata, l_rdata;

    logic                   res_vld;
    t_res                   res;
    logic                   do_new;
    logic                   var_ok;
    logic                   log_full;
    logic [HW-1:0]          cur_h;
    logic [VAR_BITS-1:0]    in_var;
    logic [BLOCK_BITS-1:0]  in_blk;
    logic [NUMBER_BITS-1:0] in_num;

    assign in_var   = s_tdata[VAR_BITS-1:0];
    assign in_blk   = s_tdata[VAR_BITS+BLOCK_BITS-1:VAR_BITS];
    assign in_num   = s_tdata[VAR_BITS+BLOCK_BITS+NUMBER_BITS-1:VAR_BITS+BLOCK_BITS];
    assign var_ok   = (32'(r_var) < NUM_VARS);
    assign log_full = (r_log_h == LW'(LOG_DEPTH));
    // height of the item in hand: straight off the RAM in the lookup cycle
    assign cur_h    = (r_state == S_HGT) ? h_rdata : r_h;

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = M_TDATA_BITS'(r_m_res);

    bsrs_ram #(.WIDTH(HW), .DEPTH(VARS), .AW(HA)) u_height (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    bsrs_ram #(.WIDTH($bits(t_entry)), .DEPTH(EDEP), .AW(EA)) u_entry (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    bsrs_ram #(.WIDTH($bits(t_log)), .DEPTH(LOG_DEPTH), .AW(LA)) u_log (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_log_h   = r_log_h;
        n_m_valid = r_m_valid & ~m_tready;
        n_op      = r_op;
        n_var     = r_var;
        n_blk     = r_blk;
        n_num     = r_num;
        n_h       = r_h;
        n_lvar    = r_lvar;
        n_cnt     = r_cnt;
        n_res     = r_res;
        n_m_res   = r_m_res;

        h_we    = 1'b0;
        h_waddr = HA'(r_var);
        h_wdata = '0;
        h_raddr = HA'(in_var);
        e_we    = 1'b0;
        e_waddr = EA'(32'(r_var) * STACK_DEPTH + 32'(cur_h));
        e_wdata = '{blk: r_blk, num: r_num};
        e_raddr = EA'(32'(r_var) * STACK_DEPTH + 32'(h_rdata) - 32'd1);
        l_we    = 1'b0;
        l_waddr = LA'(r_log_h);
        l_wdata = '{blk: r_blk, var_idx: r_var};
        l_raddr = LA'(r_log_h - LW'(1));

        res_vld = 1'b0;
        res     = '0;
        do_new  = 1'b0;

        case (r_state)
            S_CLR: begin
                h_we    = 1'b1;
                h_waddr = r_clr;
                n_clr   = r_clr + HA'(1);
                if (r_clr == HA'(VARS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    n_op    = s_tuser;
                    n_var   = in_var;
                    n_blk   = in_blk;
                    n_num   = in_num;
                    n_cnt   = '0;
                    n_state = (s_tuser == OP_POP) ? S_PCHK : S_HGT;
                end
            end
            S_HGT: begin
                n_h = h_rdata;
                if ((r_op == OP_PUSH || r_op == OP_READ) && var_ok) begin
                    if (h_rdata != '0) begin
                        n_state = S_ENT;
                    end else if (r_op == OP_READ) begin
                        res_vld    = 1'b1;
                        res.status = ST_EMPTY;
                    end else if (log_full) begin
                        res_vld    = 1'b1;
                        res.status = ST_OVF;
                    end else begin
                        do_new = 1'b1;
                    end
                end else begin
                    // unknown variable or unused code
                    res_vld = 1'b1;
                    if (r_op == OP_PUSH) begin
                        res.status = ST_OVF;
                    end else if (r_op == OP_READ) begin
                        res.status = ST_EMPTY;
                    end
                end
            end
            S_ENT: begin
                res_vld = 1'b1;
                if (r_op == OP_READ) begin
                    res.top_number = e_rdata.num;
                end else if (e_rdata.blk == r_blk) begin
                    // same block owns the top: overwrite its number
                    e_we    = 1'b1;
                    e_waddr = EA'(32'(r_var) * STACK_DEPTH + 32'(r_h) - 32'd1);
                end else if (r_h >= HW'(STACK_DEPTH) || log_full) begin
                    res.status = ST_OVF;
                end else begin
                    res_vld = 1'b0;
                    do_new  = 1'b1;
                end
            end
            S_PCHK: begin
                if (r_log_h != '0 && l_rdata.blk == r_blk) begin
                    h_raddr = HA'(l_rdata.var_idx);
                    n_lvar  = l_rdata.var_idx;
                    n_state = S_PDEC;
                end else begin
                    res_vld          = 1'b1;
                    res.popped_count = r_cnt;
                end
            end
            S_PDEC: begin
                if (32'(r_lvar) < NUM_VARS && h_rdata != '0) begin
                    h_we    = 1'b1;
                    h_waddr = HA'(r_lvar);
                    h_wdata = h_rdata - HW'(1);
                end
                n_log_h = r_log_h - LW'(1);
                n_cnt   = r_cnt + COUNT_BITS'(1);
                l_raddr = LA'(r_log_h - LW'(2));
                n_state = S_PCHK;
            end
            S_OUT: begin
                if (!r_m_valid || m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_res   = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // new stack entry plus log record
        if (do_new) begin
            e_we    = 1'b1;
            h_we    = 1'b1;
            h_wdata = cur_h + HW'(1);
            l_we    = 1'b1;
            n_log_h = r_log_h + LW'(1);
            res_vld = 1'b1;
        end

        // hand the result to the output register, or hold it
        if (res_vld) begin
            if (!r_m_valid || m_tready) begin
                n_m_valid = 1'b1;
                n_m_res   = res;
                n_state   = S_IDLE;
            end else begin
                n_res   = res;
                n_state = S_OUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_log_h   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_log_h   <= n_log_h;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_var   <= n_var;
        r_blk   <= n_blk;
        r_num   <= n_num;
        r_h     <= n_h;
        r_lvar  <= n_lvar;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
        r_m_res <= n_m_res;
    end

endmodule
